/* rtl/core/q2e_pkg.sv */
// Shared types, constants and helper functions for the quaternion to Euler angle unit.
package q2e_pkg;

  localparam int QW        = 16;
  localparam int PW        = 32;
  localparam int CW        = 37;
  localparam int ZW        = 30;
  localparam int SW        = 30;
  localparam int SQW       = 58;
  localparam int RW        = 29;
  localparam int SQ_CELLS  = 29;
  localparam int SQ_TOP    = 56;
  localparam int THR_W     = 29;
  localparam int TAB_LEN   = 32;
  localparam int FW        = 32;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(134217594);
  localparam logic signed [ZW-1:0] DEG90_FINE = ZW'(94371840);
  localparam logic signed [FW-1:0] OUT_HALF  = FW'(23040);
  localparam logic signed [FW-1:0] OUT_FULL  = FW'(46080);
  localparam logic signed [FW-1:0] OUT_QUART = FW'(11520);

  localparam logic [1:0] CASE_NORMAL = 2'd0;
  localparam logic [1:0] CASE_NEG    = 2'd1;
  localparam logic [1:0] CASE_POS    = 2'd2;

  localparam logic [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    ZW'(47185920), ZW'(27855475), ZW'(14718068), ZW'(7471121),
    ZW'(3750058),  ZW'(1876857),  ZW'(938658),   ZW'(469357),
    ZW'(234682),   ZW'(117342),   ZW'(58671),    ZW'(29335),
    ZW'(14668),    ZW'(7334),     ZW'(3667),     ZW'(1833),
    ZW'(917),      ZW'(458),      ZW'(229),      ZW'(115),
    ZW'(57),       ZW'(29),       ZW'(14),       ZW'(7),
    ZW'(4),        ZW'(2),        ZW'(1),        ZW'(0),
    ZW'(0),        ZW'(0),        ZW'(0),        ZW'(0)
  };

  typedef struct packed {
    logic                 valid;
    logic [1:0]           pcase;
    logic signed [CW-1:0] yy;
    logic signed [CW-1:0] yx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rx;
    logic signed [SW-1:0] s;
  } side_t;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [SQW-1:0] root;
    side_t          side;
  } sqrt_t;

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  pcase;
    lane_t [2:0] lane;
  } crd_t;

  // quadrant fold so the vectoring loop sees x >= 0
  function automatic lane_t prerot(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = DEG90_FINE;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -DEG90_FINE;
      end
    end
    return l;
  endfunction

  function automatic logic signed [FW-1:0] to_out(logic signed [FW-1:0] fine);
    logic signed [FW-1:0] r;
    r = (fine + FW'(4096)) >>> 13;
    return r;
  endfunction

  function automatic logic signed [FW-1:0] wrap_out(logic signed [FW-1:0] v);
    logic signed [FW-1:0] r;
    r = v;
    if (r > OUT_HALF) r = r - OUT_FULL;
    if (r > OUT_HALF) r = r - OUT_FULL;
    if (r <= -OUT_HALF) r = r + OUT_FULL;
    if (r <= -OUT_HALF) r = r + OUT_FULL;
    return r;
  endfunction

endpackage

/* rtl/core/q2e_sqrt_cell.sv */
// One digit step of the pipelined integer square root, with side data carried along.
module q2e_sqrt_cell #(
  parameter int BIT_POS = 56
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q2e_pkg::sqrt_t   d_in,
  output q2e_pkg::sqrt_t   d_out
);

  localparam logic [q2e_pkg::SQW-1:0] BIT = q2e_pkg::SQW'(1) << BIT_POS;

  q2e_pkg::sqrt_t d_r, d_nxt;
  logic [q2e_pkg::SQW-1:0] trial;

  always_comb begin
    trial = d_in.root + BIT;
    d_nxt = d_in;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root >> 1) + BIT;
    end else begin
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) d_r.side.valid <= 1'b0;
  end

  assign d_out = d_r;

endmodule

/* rtl/core/q2e_cordic_cell.sv */
// One vectoring CORDIC iteration for the pitch, yaw and roll lanes.
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  q2e_pkg::crd_t d_in,
  output q2e_pkg::crd_t d_out
);

  localparam logic signed [q2e_pkg::ZW-1:0] ANG = q2e_pkg::ATAN_TAB[STAGE];

  q2e_pkg::crd_t d_r, d_nxt;

  always_comb begin
    d_nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      if (d_in.lane[k].y >= 0) begin
        d_nxt.lane[k].x = d_in.lane[k].x + (d_in.lane[k].y >>> STAGE);
        d_nxt.lane[k].y = d_in.lane[k].y - (d_in.lane[k].x >>> STAGE);
        d_nxt.lane[k].z = d_in.lane[k].z + ANG;
      end else begin
        d_nxt.lane[k].x = d_in.lane[k].x - (d_in.lane[k].y >>> STAGE);
        d_nxt.lane[k].y = d_in.lane[k].y + (d_in.lane[k].x >>> STAGE);
        d_nxt.lane[k].z = d_in.lane[k].z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (!rst_n) d_r.valid <= 1'b0;
  end

  assign d_out = d_r;

endmodule

/* rtl/core/quaternion_to_euler_angles_unit.sv */
// Top level: quaternion to pitch/yaw/roll in units of 1/128 degree, fully pipelined.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-----------------------
//   request  | in_quat_x/y/z/w                         | start, busy (always 0)
//   result   | out_pitch_deg/yaw_deg/roll_deg/pole_case| out_valid strobe
//   config   | cfg_pole_threshold                      | cfg_valid, cfg_ready
//
// One request per cycle. Registered stages in order: products, sums,
// square, remainder, 29 square root cells, quadrant fold, CORDIC cells,
// output rounding. Reset clears the valid line and restores the threshold.
// The result side has no stall; each result shows for one cycle.
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [15:0]             in_quat_x,
  input  logic signed [15:0]             in_quat_y,
  input  logic signed [15:0]             in_quat_z,
  input  logic signed [15:0]             in_quat_w,
  output logic                           out_valid,
  output logic signed [14:0]             out_pitch_deg,
  output logic signed [15:0]             out_yaw_deg,
  output logic signed [15:0]             out_roll_deg,
  output logic [1:0]                     out_pole_case,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [q2e_pkg::THR_W-1:0]      cfg_pole_threshold
);

  localparam int CW = q2e_pkg::CW;
  localparam int FW = q2e_pkg::FW;
  localparam int PW = q2e_pkg::PW;

  logic [q2e_pkg::THR_W-1:0] thr_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= q2e_pkg::THR_RESET;
    else if (cfg_valid && cfg_ready) thr_r <= cfg_pole_threshold;
  end

  // products
  logic v0_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, xy_r, zx_r, wy_r, wz_r, wx_r, yz_r;
  logic signed [15:0]   x0_r, w0_r;

  always_ff @(posedge clk) begin
    v0_r <= rst_n && start && !busy;
    xx_r <= PW'(in_quat_x * in_quat_x);
    yy_r <= PW'(in_quat_y * in_quat_y);
    zz_r <= PW'(in_quat_z * in_quat_z);
    xy_r <= PW'(in_quat_x * in_quat_y);
    zx_r <= PW'(in_quat_z * in_quat_x);
    wy_r <= PW'(in_quat_w * in_quat_y);
    wz_r <= PW'(in_quat_w * in_quat_z);
    wx_r <= PW'(in_quat_w * in_quat_x);
    yz_r <= PW'(in_quat_y * in_quat_z);
    x0_r <= in_quat_x;
    w0_r <= in_quat_w;
  end

  // sums, pole test, asin argument
  q2e_pkg::side_t s1_nxt, s1_r;
  logic signed [CW-1:0] t_w, thr_w, s2_w, one_w;

  always_comb begin
    one_w = CW'(268435456);
    t_w   = CW'(zx_r) - CW'(wy_r);
    thr_w = CW'(thr_r);
    s2_w  = t_w <<< 1;
    s1_nxt.valid = v0_r;
    s1_nxt.yy = (CW'(wz_r) + CW'(xy_r)) <<< 1;
    s1_nxt.yx = one_w - ((CW'(yy_r) + CW'(zz_r)) <<< 1);
    if (t_w < -thr_w) s1_nxt.pcase = q2e_pkg::CASE_NEG;
    else if (t_w > thr_w) s1_nxt.pcase = q2e_pkg::CASE_POS;
    else s1_nxt.pcase = q2e_pkg::CASE_NORMAL;
    if (s1_nxt.pcase == q2e_pkg::CASE_NORMAL) begin
      s1_nxt.ry = -((CW'(wx_r) + CW'(yz_r)) <<< 1);
      s1_nxt.rx = one_w - ((CW'(xx_r) + CW'(yy_r)) <<< 1);
    end else begin
      s1_nxt.ry = CW'(x0_r) <<< 14;
      s1_nxt.rx = CW'(w0_r) <<< 14;
    end
    if (s2_w > one_w) s2_w = one_w;
    if (s2_w < -one_w) s2_w = -one_w;
    s1_nxt.s = q2e_pkg::SW'(s2_w);
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (!rst_n) s1_r.valid <= 1'b0;
  end

  // square of the asin argument
  q2e_pkg::side_t s2_r;
  logic [2*q2e_pkg::SW-1:0] sq_r;

  always_ff @(posedge clk) begin
    s2_r <= s1_r;
    sq_r <= (2*q2e_pkg::SW)'(s1_r.s * s1_r.s);
    if (!rst_n) s2_r.valid <= 1'b0;
  end

  // radicand
  q2e_pkg::sqrt_t sq_chain [q2e_pkg::SQ_CELLS+1];
  q2e_pkg::sqrt_t s3_r;

  always_ff @(posedge clk) begin
    s3_r.side <= s2_r;
    s3_r.rem  <= (q2e_pkg::SQW'(1) << q2e_pkg::SQ_TOP) - q2e_pkg::SQW'(sq_r);
    s3_r.root <= '0;
    if (!rst_n) s3_r.side.valid <= 1'b0;
  end

  assign sq_chain[0] = s3_r;

  for (genvar g = 0; g < q2e_pkg::SQ_CELLS; g++) begin : g_sqrt
    q2e_sqrt_cell #(.BIT_POS(q2e_pkg::SQ_TOP - 2*g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (sq_chain[g]),
      .d_out (sq_chain[g+1])
    );
  end

  // quadrant fold into the CORDIC row
  q2e_pkg::sqrt_t sq_end;
  q2e_pkg::crd_t  crd_chain [CORDIC_STAGES+1];
  q2e_pkg::crd_t  fold_r;

  assign sq_end = sq_chain[q2e_pkg::SQ_CELLS];

  always_ff @(posedge clk) begin
    fold_r.valid   <= sq_end.side.valid;
    fold_r.pcase   <= sq_end.side.pcase;
    fold_r.lane[0] <= q2e_pkg::prerot(CW'(sq_end.side.s),
                                      CW'({1'b0, sq_end.root[q2e_pkg::RW-1:0]}));
    fold_r.lane[1] <= q2e_pkg::prerot(sq_end.side.yy, sq_end.side.yx);
    fold_r.lane[2] <= q2e_pkg::prerot(sq_end.side.ry, sq_end.side.rx);
    if (!rst_n) fold_r.valid <= 1'b0;
  end

  assign crd_chain[0] = fold_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    q2e_cordic_cell #(.STAGE(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (crd_chain[g]),
      .d_out (crd_chain[g+1])
    );
  end

  // rounding, pole combination, wrap
  q2e_pkg::crd_t c_end;
  logic signed [FW-1:0] pz_w, yz_w, rz_w, pit_w, yaw_w, rol_w;

  assign c_end = crd_chain[CORDIC_STAGES];

  always_comb begin
    pz_w = c_end.lane[0].zero ? '0 : FW'(c_end.lane[0].z);
    yz_w = c_end.lane[1].zero ? '0 : FW'(c_end.lane[1].z);
    rz_w = c_end.lane[2].zero ? '0 : FW'(c_end.lane[2].z);
    yaw_w = q2e_pkg::wrap_out(q2e_pkg::to_out(yz_w));
    pit_w = q2e_pkg::to_out(pz_w);
    if (pit_w > q2e_pkg::OUT_QUART) pit_w = q2e_pkg::OUT_QUART;
    if (pit_w < -q2e_pkg::OUT_QUART) pit_w = -q2e_pkg::OUT_QUART;
    rol_w = q2e_pkg::wrap_out(q2e_pkg::to_out(rz_w));
    case (c_end.pcase)
      q2e_pkg::CASE_NEG: begin
        pit_w = -q2e_pkg::OUT_QUART;
        rol_w = q2e_pkg::wrap_out(q2e_pkg::to_out(-yz_w - (rz_w <<< 1)));
      end
      q2e_pkg::CASE_POS: begin
        pit_w = q2e_pkg::OUT_QUART;
        rol_w = q2e_pkg::wrap_out(q2e_pkg::to_out(yz_w - (rz_w <<< 1)));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= c_end.valid;
    out_pitch_deg <= pit_w[14:0];
    out_yaw_deg   <= yaw_w[15:0];
    out_roll_deg  <= rol_w[15:0];
    out_pole_case <= c_end.pcase;
  end

endmodule
